/* sv/alcc_pkg.sv */
// Shared types and constants for the ambient light contrast controller.
`default_nettype none
package alcc_pkg;

	localparam int unsigned RAW_W  = 16;
	localparam int unsigned LUX_W  = 16;
	localparam int unsigned LVL_W  = 8;
	localparam int unsigned RAW5_W = RAW_W + 3;
	localparam int unsigned PROD_W = LUX_W + LVL_W;
	localparam int unsigned CNT_W  = 5;
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	// lux = raw*5/6, quotient bits worked one per cycle
	localparam logic [CNT_W-1:0] LUX_LAST = CNT_W'(RAW5_W - 1);
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(LVL_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);
	localparam logic [LUX_W-1:0] LUX_DIVISOR = LUX_W'(6);

	localparam logic [LUX_W-1:0] FLOOR_RST = LUX_W'(1);
	localparam logic [LUX_W-1:0] CEIL_RST  = LUX_W'(50);
	localparam logic [LVL_W-1:0] CMIN_RST  = LVL_W'(3);
	localparam logic [LVL_W-1:0] CMAX_RST  = LVL_W'(255);

	localparam logic [LVL_W-1:0] SLEW_DEADBAND = LVL_W'(2);
	localparam logic [LVL_W-1:0] SLEW_MIN_STEP = LVL_W'(2);
	localparam int unsigned      SLEW_SHIFT    = 5;

	typedef enum logic [1:0] {
		REG_LUX_FLOOR    = 2'd0,
		REG_LUX_CEILING  = 2'd1,
		REG_CONTRAST_MIN = 2'd2,
		REG_CONTRAST_MAX = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LUX_DIV,
		ST_TARGET,
		ST_MUL,
		ST_DIV,
		ST_SLEW,
		ST_HOLD
	} state_t;

endpackage
`default_nettype wire

/* sv/ambient_light_contrast_controller_top.sv */
// Ambient light contrast controller: lux conversion, target mapping and slew.
//
//  channel   dir  fields (low bit up)                               handshake
//  s_axis    in   tdata: raw_light[15:0]                            tvalid/tready
//  m_axis    out  tdata: lux_value, target_level, drive_level;      tvalid/tready
//                 tuser: level_changed
//  apb       in   lux_floor@0x0, lux_ceiling@0x4, contrast_min@0x8,  psel/penable
//                 contrast_max@0xC
//
// One word at a time. When the target is interpolated, a word passes a
// bit-serial divide by 6, a shift-add multiply and a restoring divide before
// the next possible accept; when the lux lies outside the band or the band is
// empty, the multiply and divide are skipped. A finished word waits in the
// output register while the next input is taken; a word still waiting there
// stalls the next one in its last state. Reset clears control state and loads
// register defaults.
`default_nettype none
module ambient_light_contrast_controller_top
	import alcc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [RAW_W-1:0]  s_tdata,   // [15:0] raw_light
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [31:0]            m_tdata,   // [15:0] lux_value, [23:16] target_level,
	                                          // [31:24] drive_level
	output logic                   m_tuser,   // [0] level_changed
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	state_t state_q, state_nxt;

	logic [LUX_W-1:0]  floor_q, ceil_q;
	logic [LVL_W-1:0]  cmin_q, cmax_q;
	logic [LVL_W-1:0]  cur_q;

	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] dvd_q;
	logic [LUX_W-1:0]  rem_q, den_q, mcand_q, lux_q;
	logic [LVL_W-1:0]  span_q, tgt_q;
	logic              up_q, interp_q;

	logic              out_valid_q;
	logic [31:0]       out_data_q;
	logic              out_user_q;

	// config port
	logic     wr_en;
	reg_idx_t widx;
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign widx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= FLOOR_RST;
			ceil_q  <= CEIL_RST;
			cmin_q  <= CMIN_RST;
			cmax_q  <= CMAX_RST;
		end else if (wr_en) begin
			unique case (widx)
				REG_LUX_FLOOR:    floor_q <= pwdata[LUX_W-1:0];
				REG_LUX_CEILING:  ceil_q  <= pwdata[LUX_W-1:0];
				REG_CONTRAST_MIN: cmin_q  <= pwdata[LVL_W-1:0];
				REG_CONTRAST_MAX: cmax_q  <= pwdata[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_LUX_FLOOR:    prdata = {{(DATA_W-LUX_W){1'b0}}, floor_q};
			REG_LUX_CEILING:  prdata = {{(DATA_W-LUX_W){1'b0}}, ceil_q};
			REG_CONTRAST_MIN: prdata = {{(DATA_W-LVL_W){1'b0}}, cmin_q};
			REG_CONTRAST_MAX: prdata = {{(DATA_W-LVL_W){1'b0}}, cmax_q};
			default:          prdata = '0;
		endcase
	end

	// restoring divider step, one quotient bit per cycle
	logic [LUX_W:0]    rem_sh, trial;
	logic              fits;
	logic [LUX_W-1:0]  rem_nxt;
	logic [PROD_W-1:0] dvd_nxt;
	assign rem_sh  = {rem_q, dvd_q[PROD_W-1]};
	assign trial   = rem_sh - {1'b0, den_q};
	assign fits    = rem_sh >= {1'b0, den_q};
	assign rem_nxt = fits ? trial[LUX_W-1:0] : rem_sh[LUX_W-1:0];
	assign dvd_nxt = {dvd_q[PROD_W-2:0], fits};

	logic [RAW5_W-1:0] raw5;
	assign raw5 = {1'b0, s_tdata, 2'b00} + {3'b000, s_tdata};

	// band decision on the fresh lux
	logic [LUX_W-1:0] lux_now, den_now;
	logic             lux_lo, lux_hi, up_now;
	logic [LVL_W-1:0] span_now;
	assign lux_now  = dvd_q[LUX_W-1:0];
	assign lux_lo   = lux_now < floor_q;
	assign lux_hi   = lux_now > ceil_q;
	assign den_now  = ceil_q - floor_q;
	assign up_now   = cmax_q >= cmin_q;
	assign span_now = up_now ? (cmax_q - cmin_q) : (cmin_q - cmax_q);

	logic trivial;
	assign trivial = lux_lo || lux_hi || (den_now == '0);

	// slew
	logic [LVL_W-1:0] off, tgt_eff, clamp_lo, clamp, diff, step, cur_nxt;
	logic             chg;
	always_comb begin
		off      = dvd_q[LVL_W-1:0];
		tgt_eff  = interp_q ? (up_q ? (cmin_q + off) : (cmin_q - off)) : tgt_q;
		clamp_lo = (cur_q < cmin_q) ? cmin_q : cur_q;
		clamp    = (clamp_lo > cmax_q) ? cmax_q : clamp_lo;
		diff     = (clamp > tgt_eff) ? (clamp - tgt_eff) : (tgt_eff - clamp);
		step     = diff >> SLEW_SHIFT;
		if (step < SLEW_MIN_STEP) begin
			step = SLEW_MIN_STEP;
		end
		chg     = diff > SLEW_DEADBAND;
		cur_nxt = clamp;
		if (chg) begin
			cur_nxt = (clamp < tgt_eff) ? (clamp + step) : (clamp - step);
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:    if (s_tvalid) state_nxt = ST_LUX_DIV;
			ST_LUX_DIV: if (cnt_q == LUX_LAST) state_nxt = ST_TARGET;
			ST_TARGET:  state_nxt = trivial ? ST_SLEW : ST_MUL;
			ST_MUL:     if (cnt_q == MUL_LAST) state_nxt = ST_DIV;
			ST_DIV:     if (cnt_q == DIV_LAST) state_nxt = ST_SLEW;
			ST_SLEW:    state_nxt = ST_HOLD;
			ST_HOLD:    if (!out_valid_q || m_tready) state_nxt = ST_IDLE;
			default:    state_nxt = ST_IDLE;
		endcase
	end

	// handshake outputs
	logic load_out;
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		load_out = (state_q == ST_HOLD) && (!out_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			cur_q       <= CMIN_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if ((state_q == ST_IDLE) || (state_q == ST_TARGET) ||
			    ((state_q == ST_MUL) && (cnt_q == MUL_LAST))) begin
				cnt_q <= '0;
			end else if ((state_q == ST_LUX_DIV) || (state_q == ST_MUL) ||
			             (state_q == ST_DIV)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (state_q == ST_SLEW) begin
				cur_q <= cur_nxt;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q) inside
			ST_IDLE: begin
				if (s_tvalid) begin
					dvd_q <= {raw5, {(PROD_W-RAW5_W){1'b0}}};
					rem_q <= '0;
					den_q <= LUX_DIVISOR;
				end
			end
			ST_LUX_DIV, ST_DIV: begin
				dvd_q <= dvd_nxt;
				rem_q <= rem_nxt;
			end
			ST_TARGET: begin
				lux_q    <= lux_now;
				interp_q <= !trivial;
				up_q     <= up_now;
				span_q   <= span_now;
				den_q    <= den_now;
				mcand_q  <= lux_now - floor_q;
				rem_q    <= '0;
				dvd_q    <= '0;
				if (lux_lo) begin
					tgt_q <= cmin_q;
				end else if (lux_hi) begin
					tgt_q <= cmax_q;
				end else begin
					tgt_q <= cmin_q;
				end
			end
			ST_MUL: begin
				dvd_q  <= {dvd_q[PROD_W-2:0], 1'b0} +
				          (span_q[LVL_W-1] ? {{(PROD_W-LUX_W){1'b0}}, mcand_q} : '0);
				span_q <= {span_q[LVL_W-2:0], 1'b0};
			end
			ST_SLEW: begin
				out_data_q <= {cur_nxt, tgt_eff, lux_q};
				out_user_q <= chg;
			end
			default: ;
		endcase
	end

	logic [31:0] m_data_q;
	logic        m_user_q;
	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q <= out_data_q;
			m_user_q <= out_user_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule
`default_nettype wire
